/* rtl/core/fmps_pkg.sv */
// ----------------------------------------------------------------------------
// fmps_pkg: shared types and constants for the flow meter statistics unit
// Action codes, register indexes, field widths, reset values and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package fmps_pkg;

  // action codes carried in in_tuser
  localparam logic [1:0] ACT_PULSE    = 2'd0;
  localparam logic [1:0] ACT_INTERVAL = 2'd1;
  localparam logic [1:0] ACT_ROLLOVER = 2'd2;

  // configuration register indexes
  localparam logic REG_INTERVAL = 1'b0;
  localparam logic REG_FACTOR   = 1'b1;

  localparam int ACT_W   = 2;
  localparam int IVL_W   = 12;
  localparam int FAC_W   = 16;
  localparam int ELAP_W  = 16;
  localparam int CFG_W   = 16;
  localparam int CNT16_W = 16;
  localparam int RATE_W  = 32;
  localparam int VOL_W   = 48;
  localparam int STAT_W  = 32;
  localparam int NUM_W   = 38;
  localparam int DEN_W   = 38;
  localparam int M1_W    = 22;
  localparam int OUT_W   = 304;

  localparam logic [IVL_W-1:0] IVL_RESET = 12'd1;
  localparam logic [FAC_W-1:0] FAC_RESET = 16'd1920;

  localparam int MS_PER_S  = 1000;
  localparam int S_PER_MIN = 60;

  // rate quotient comes out 32 bits, one bit per step
  localparam int DIV_STEPS = 32;
  localparam int CNT_W     = 5;

  typedef struct packed {
    logic acc_pulse;  // pulse word taken
    logic acc_intv;   // interval-end word taken
    logic acc_roll;   // day rollover word taken
    logic mul;        // form numerator and denominator
    logic chk;        // overflow check, load divider
    logic div_step;   // one restoring division step
    logic upd;        // apply rate and episode update
    logic avg_wr;     // write average from divider
    logic snap;       // capture result into output register
  } fmps_cmd_t;

  typedef struct packed {
    logic avg_start;  // episode ended, average division needed
  } fmps_sts_t;

endpackage

/* rtl/core/fmps_ctrl.sv */
// ----------------------------------------------------------------------------
// fmps_ctrl: sequencer for the flow meter statistics unit
// Accepts one word at a time, steps the datapath through multiply, divide
// and update, and owns the output valid flag.
// ----------------------------------------------------------------------------
module fmps_ctrl
  import fmps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [ACT_W-1:0] in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  fmps_sts_t        sts,
  output fmps_cmd_t        cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_ADIV = 3'd5;
  localparam logic [2:0] S_AVGW = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             acc;
  logic             cnt_last;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign acc        = in_tvalid && in_tready;
  assign cnt_last   = (cnt_r == CNT_W'(DIV_STEPS - 1));

  always_comb begin
    cmd           = '0;
    cmd.acc_pulse = acc && (in_tuser == ACT_PULSE);
    cmd.acc_intv  = acc && (in_tuser == ACT_INTERVAL);
    cmd.acc_roll  = acc && (in_tuser == ACT_ROLLOVER);
    cmd.mul       = (state_r == S_MUL);
    cmd.chk       = (state_r == S_CHK);
    cmd.div_step  = (state_r == S_DIV) || (state_r == S_ADIV);
    cmd.upd       = (state_r == S_UPD);
    cmd.avg_wr    = (state_r == S_AVGW);
    cmd.snap      = (state_r == S_FIN) && (!out_valid_r || out_tready);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          state_nxt = (in_tuser == ACT_INTERVAL) ? S_MUL : S_FIN;
        end
      end
      S_MUL: state_nxt = S_CHK;
      S_CHK: begin
        state_nxt = S_DIV;
        cnt_nxt   = '0;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cnt_nxt   = '0;
        state_nxt = sts.avg_start ? S_ADIV : S_FIN;
      end
      S_ADIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          state_nxt = S_AVGW;
        end
      end
      S_AVGW: state_nxt = S_FIN;
      S_FIN: begin
        if (cmd.snap) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold valid until the word is taken; a new snapshot refills it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.snap) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_intv_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_intv |=> state_r == S_MUL)
    else $error("interval word did not start the multiply step");

  a_div_to_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && cnt_last |=> state_r == S_UPD)
    else $error("rate division did not end in update");

  a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && !cmd.snap |=> (state_r == S_FIN) && out_valid_r)
    else $error("result dropped while output register full");

  a_snap_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.snap |=> out_valid_r && (state_r == S_IDLE))
    else $error("snapshot did not raise output valid");

endmodule

/* rtl/core/fmps_dp.sv */
// ----------------------------------------------------------------------------
// fmps_dp: datapath for the flow meter statistics unit
// Configuration registers, daily statistics, rate multipliers, a shared
// restoring divider for rate and average, and the output register.
// ----------------------------------------------------------------------------
module fmps_dp
  import fmps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  fmps_cmd_t         cmd,
  output fmps_sts_t         sts,
  input  logic [ELAP_W-1:0] in_elapsed,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output logic [OUT_W-1:0]  out_data
);

  // configuration
  logic [IVL_W-1:0]   ivl_r;
  logic [FAC_W-1:0]   fac_r;

  // architectural statistics
  logic [CNT16_W-1:0] tally_r;
  logic [CNT16_W-1:0] fin_r;
  logic [RATE_W-1:0]  rate_r;
  logic [VOL_W-1:0]   vol_r;
  logic [VOL_W-1:0]   yest_r;
  logic [STAT_W-1:0]  run_now_r;
  logic [STAT_W-1:0]  run_max_r;
  logic [STAT_W-1:0]  run_min_r;
  logic [STAT_W-1:0]  run_avg_r;
  logic [STAT_W-1:0]  run_total_r;
  logic [STAT_W-1:0]  episodes_r;

  // working registers
  logic [RATE_W-1:0]  ef_r;
  logic [M1_W-1:0]    m1_r;
  logic [NUM_W-1:0]   num_r;
  logic [DEN_W-1:0]   den_r;
  logic [DEN_W-1:0]   rem_r;
  logic [STAT_W-1:0]  dq_r;
  logic               ovf_r;
  logic [OUT_W-1:0]   out_data_r;

  logic [ELAP_W-1:0]  elap_fix;
  logic [DEN_W:0]     rem_sh;
  logic [DEN_W:0]     rem_sub;
  logic               rem_ge;
  logic [RATE_W-1:0]  rate_q;
  logic               rate_zero;
  logic               prev_nz;
  logic [VOL_W:0]     vol_sum;
  logic [STAT_W:0]    run_sum;
  logic [STAT_W:0]    total_sum;

  assign elap_fix = (in_elapsed == '0) ? ELAP_W'(1) : in_elapsed;

  // restoring division step: shift in next dividend bit, subtract if it fits
  assign rem_sh  = {rem_r, dq_r[STAT_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, den_r});
  assign rem_sub = rem_sh - {1'b0, den_r};

  assign rate_q    = ovf_r ? '1 : dq_r;
  assign rate_zero = (rate_q == '0);
  assign prev_nz   = (rate_r != '0);
  assign vol_sum   = {1'b0, vol_r} + (VOL_W + 1)'(rate_q);
  assign run_sum   = {1'b0, run_now_r} + (STAT_W + 1)'(ivl_r);
  assign total_sum = {1'b0, run_total_r} + (STAT_W + 1)'(ivl_r);

  assign sts.avg_start = rate_zero && prev_nz && (episodes_r != '0);
  assign out_data      = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivl_r <= IVL_RESET;
      fac_r <= FAC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INTERVAL: ivl_r <= cfg_wdata[IVL_W-1:0];
        REG_FACTOR: begin
          // drop a zero factor
          if (cfg_wdata != '0) begin
            fac_r <= cfg_wdata[FAC_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r     <= '0;
      fin_r       <= '0;
      rate_r      <= '0;
      vol_r       <= '0;
      yest_r      <= '0;
      run_now_r   <= '0;
      run_max_r   <= '0;
      run_min_r   <= '0;
      run_avg_r   <= '0;
      run_total_r <= '0;
      episodes_r  <= '0;
    end else begin
      if (cmd.acc_pulse && (tally_r != '1)) begin
        tally_r <= tally_r + 1'b1;
      end
      if (cmd.acc_roll) begin
        yest_r      <= vol_r;
        vol_r       <= '0;
        run_max_r   <= '0;
        run_min_r   <= '0;
        run_avg_r   <= '0;
        run_total_r <= '0;
        episodes_r  <= '0;
      end
      if (cmd.upd) begin
        rate_r  <= rate_q;
        vol_r   <= vol_sum[VOL_W] ? '1 : vol_sum[VOL_W-1:0];
        fin_r   <= tally_r;
        tally_r <= '0;
        if (rate_zero) begin
          if (prev_nz) begin
            // episode ends
            if (run_now_r > run_max_r) begin
              run_max_r <= run_now_r;
            end
            if ((run_min_r == '0) || (run_now_r < run_min_r)) begin
              run_min_r <= run_now_r;
            end
            if (episodes_r == '0) begin
              run_avg_r <= '0;
            end
            run_now_r <= '0;
          end
        end else begin
          if (!prev_nz && (episodes_r != '1)) begin
            episodes_r <= episodes_r + 1'b1;
          end
          run_now_r   <= run_sum[STAT_W] ? '1 : run_sum[STAT_W-1:0];
          run_total_r <= total_sum[STAT_W] ? '1 : total_sum[STAT_W-1:0];
        end
      end
      if (cmd.avg_wr) begin
        run_avg_r <= dq_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_intv) begin
      ef_r <= RATE_W'(elap_fix) * RATE_W'(fac_r);
      m1_r <= M1_W'(ivl_r) * M1_W'(MS_PER_S);
    end
    if (cmd.mul) begin
      num_r <= NUM_W'(m1_r) * NUM_W'(tally_r);
      den_r <= DEN_W'(ef_r) * DEN_W'(S_PER_MIN);
    end
    if (cmd.chk) begin
      // dividend is num << 24; quotient overflows 32 bits when num >> 8 >= den
      ovf_r <= (DEN_W'(num_r[NUM_W-1:8]) >= den_r);
      rem_r <= DEN_W'(num_r[NUM_W-1:8]);
      dq_r  <= {num_r[7:0], 24'd0};
    end
    if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      dq_r  <= {dq_r[STAT_W-2:0], rem_ge};
    end
    if (cmd.upd) begin
      // load average division: run_total / episodes
      rem_r <= '0;
      dq_r  <= run_total_r;
      den_r <= DEN_W'(episodes_r);
    end
    if (cmd.snap) begin
      out_data_r <= {fin_r, episodes_r, run_total_r, run_avg_r, run_min_r,
                     run_max_r, yest_r, vol_r, rate_r};
    end
  end

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    run_min_r <= run_max_r)
    else $error("shortest run exceeds longest run");

  a_avg_needs_episode: assert property (@(posedge clk) disable iff (!rst_n)
    (episodes_r == '0) |-> (run_avg_r == '0))
    else $error("average set with no episodes");

  a_vol_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.acc_roll |=> vol_r >= $past(vol_r))
    else $error("volume decreased without rollover");

  a_run_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (rate_r == '0) |-> (run_now_r == '0))
    else $error("current run nonzero while flow stopped");

endmodule

/* rtl/core/flow_meter_pulse_statistics_unit.sv */
// ----------------------------------------------------------------------------
// flow_meter_pulse_statistics_unit: pulse flow meter totalizer
// Tallies sensor pulses, turns each interval into a flow rate, totals the
// daily volume and keeps flow episode statistics.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+---------------------------------
//  in_     | slave     | tvalid / tready   | tuser action, tdata elapsed_ms
//  out_    | master    | tvalid / tready   | tdata statistics snapshot
//  cfg_    | write     | cfg_we            | cfg_index, cfg_wdata
//
//  Pulse and rollover words go from accept straight to the result snapshot.
//  Interval-end words pass multiply, check, the 32-step restoring divider
//  and update; an episode end reruns the divider to recompute the average.
//  One word is in flight at a time; the next is accepted once the result
//  sits in the output register, which holds it while out_tready is low.
//  Reset (rst_n, synchronous) clears all statistics and loads the
//  register defaults.
// ----------------------------------------------------------------------------
module flow_meter_pulse_statistics_unit
  import fmps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [ELAP_W-1:0] in_tdata,   // [15:0] elapsed_ms
  input  logic [ACT_W-1:0]  in_tuser,   // [1:0] action
  output logic              out_tvalid,
  input  logic              out_tready,
  // [31:0] flow_rate, [79:32] cumulative_volume, [127:80] yesterday_volume,
  // [159:128] longest_run, [191:160] shortest_run, [223:192] average_run,
  // [255:224] total_run, [287:256] episode_count,
  // [303:288] last_interval_pulses
  output logic [OUT_W-1:0]  out_tdata,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  fmps_cmd_t cmd;
  fmps_sts_t sts;

  fmps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  fmps_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_elapsed (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index[0]),
    .cfg_wdata  (cfg_wdata),
    .out_data   (out_tdata)
  );

endmodule
